/* rtl/depq_pkg.sv */
// Shared types and codes for the double-ended priority queue.
package depq_pkg;

   typedef enum logic [1:0] {
      REQ_INSERT   = 2'd0,
      REQ_TAKE_MAX = 2'd1,
      REQ_TAKE_MIN = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_SPARE = 2'd3
   } status_code_type;

   typedef struct packed {
      logic ins;
      logic take_max;
      logic take_min;
   } cell_ctl_type;

   localparam int VALUE_W = 32;
   localparam int COUNT_OUT_W = 7;

endpackage

/* rtl/depq_cell.sv */
// One cell of the sorted chain: holds one value and its occupied flag.
module depq_cell (
   input  logic                                    clock,
   input  logic                                    reset,
   input  depq_pkg::cell_ctl_type                  ctl,
   input  logic signed [depq_pkg::VALUE_W-1:0]     key,
   input  logic                                    left_lt,
   input  logic                                    left_occ,
   input  logic signed [depq_pkg::VALUE_W-1:0]     left_value,
   input  logic                                    right_occ,
   input  logic signed [depq_pkg::VALUE_W-1:0]     right_value,
   output logic signed [depq_pkg::VALUE_W-1:0]     value,
   output logic                                    lt,
   output logic                                    occ,
   output logic signed [depq_pkg::VALUE_W-1:0]     top_value
);
   import depq_pkg::*;

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      occ_ff;
   logic                      occ_in;

   // An empty cell behaves as if it held a value above every key.
   assign lt        = !occ_ff || (key < value_ff);
   assign value     = value_ff;
   assign occ       = occ_ff;
   assign top_value = (occ_ff && !right_occ) ? value_ff : '0;

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      priority if (ctl.ins) begin
         occ_in = occ_ff || left_occ;
         if (left_lt) begin
            value_in = left_value;
         end else if (lt) begin
            value_in = key;
         end
      end else if (ctl.take_min) begin
         occ_in   = right_occ;
         value_in = right_value;
      end else if (ctl.take_max) begin
         occ_in = right_occ;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      value_ff <= value_in;
   end

endmodule

/* rtl/double_ended_priority_queue.sv */
// Top level of the double-ended priority queue built from a chain of sorting cells.
//
// A request word on the req_ channel carries a code and a signed 32-bit value.
// Insert places the value in ascending order after any equal stored values;
// remove largest and remove smallest return the value taken from that end.
// Every request gives exactly one response word on the rsp_ channel with the
// removed value (zero unless a removal succeeded), a status and the element
// count after the request. Removal from an empty queue reports empty, and an
// insert into a full queue reports full and drops the value; neither changes
// the contents. The unused code changes nothing and reports ok.
// In the cell chain every cell compares the key with its own value and shifts
// in the same clock as the request is accepted, and the response register
// shows the result in the next cycle. One request is accepted per cycle
// as long as the response register is free or being taken.
// While the receiver stalls, the response holds and req_stall is raised.
// Reset empties the queue at once and drops any pending response.
module double_ended_priority_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic [1:0]                                    req_type,
   input  logic signed [depq_pkg::VALUE_W-1:0]           req_item_value,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic signed [depq_pkg::VALUE_W-1:0]           rsp_out_value,
   output logic [1:0]                                    rsp_status,
   output logic [depq_pkg::COUNT_OUT_W-1:0]              rsp_item_count
);
   import depq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic signed [VALUE_W-1:0] cell_top   [CAPACITY];
   logic [CAPACITY-1:0]       cell_lt;
   logic [CAPACITY-1:0]       cell_occ;

   logic                      accept;
   logic                      full;
   logic                      empty;
   cell_ctl_type              ctl;
   logic signed [VALUE_W-1:0] max_value;

   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic signed [VALUE_W-1:0] rsp_value_in;
   logic [1:0]                rsp_status_ff;
   logic [1:0]                rsp_status_in;
   logic [COUNT_OUT_W+CW-1:0] count_wide;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign ctl.ins      = accept && (req_type == REQ_INSERT) && !full;
   assign ctl.take_max = accept && (req_type == REQ_TAKE_MAX) && !empty;
   assign ctl.take_min = accept && (req_type == REQ_TAKE_MIN) && !empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      l_lt;
      logic                      l_occ;
      logic signed [VALUE_W-1:0] l_value;
      logic                      r_occ;
      logic signed [VALUE_W-1:0] r_value;

      if (i == 0) begin : g_first
         assign l_lt    = 1'b0;
         assign l_occ   = 1'b1;
         assign l_value = '0;
      end else begin : g_mid
         assign l_lt    = cell_lt[i-1];
         assign l_occ   = cell_occ[i-1];
         assign l_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign r_occ   = 1'b0;
         assign r_value = cell_value[i];
      end else begin : g_inner
         assign r_occ   = cell_occ[i+1];
         assign r_value = cell_value[i+1];
      end

      depq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .key         (req_item_value),
         .left_lt     (l_lt),
         .left_occ    (l_occ),
         .left_value  (l_value),
         .right_occ   (r_occ),
         .right_value (r_value),
         .value       (cell_value[i]),
         .lt          (cell_lt[i]),
         .occ         (cell_occ[i]),
         .top_value   (cell_top[i])
      );
   end

   // Only the highest occupied cell drives a nonzero top value.
   always_comb begin
      max_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         max_value = max_value | cell_top[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         unique case (req_type)
            REQ_INSERT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            REQ_TAKE_MAX: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_value_in = max_value;
                  count_in     = count_ff - CW'(1);
               end
            end
            REQ_TAKE_MIN: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_value_in = cell_value[0];
                  count_in     = count_ff - CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign count_wide     = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_count = count_wide[COUNT_OUT_W-1:0];

   // The occupied flags of the chain must agree with the element count.
   a_first_occ: assert property (@(posedge clock) disable iff (reset)
      cell_occ[0] == (count_ff != '0))
      else $error("first cell occupancy disagrees with count");

   a_last_occ: assert property (@(posedge clock) disable iff (reset)
      cell_occ[CAPACITY-1] == (count_ff == CW'(CAPACITY)))
      else $error("last cell occupancy disagrees with count");

   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_occ) == int'(count_ff))
      else $error("number of occupied cells differs from count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("count exceeds capacity");

   a_ok_insert: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> (count_ff == $past(count_ff) + CW'(1)) && (rsp_status_ff == ST_OK))
      else $error("insert did not grow the queue");

endmodule
